FILE: rtl/atm_pkg.sv
// ----------------------------------------------------------------------------
// atm_pkg
// Shared types, constants and the coefficient lookup of the anaglyph tint
// matrix.
// ----------------------------------------------------------------------------
package atm_pkg;

    // Channel and pixel layout. Channel 0 is red, 1 is green, 2 is blue.
    localparam int CHAN_W  = 8;
    localparam int NUM_CH  = 3;
    localparam int MODE_W  = 3;
    localparam int COEF_W  = 15;
    localparam int PROD_W  = 24;
    localparam int SUM_W   = 24;

    typedef logic [CHAN_W-1:0]        t_chan;
    typedef t_chan [NUM_CH-1:0]       t_pixel;
    typedef logic [MODE_W-1:0]        t_mode;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef t_prod [NUM_CH-1:0]       t_prod_row;
    typedef t_prod_row [NUM_CH-1:0]   t_prod_mat;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef t_sum [NUM_CH-1:0]        t_sum_vec;

    // Tint modes.
    localparam t_mode MODE_ORIGINAL  = 3'd0;
    localparam t_mode MODE_GRAY      = 3'd1;
    localparam t_mode MODE_TRUE      = 3'd2;
    localparam t_mode MODE_HALF      = 3'd3;
    localparam t_mode MODE_OPTIMIZED = 3'd4;
    localparam t_mode MODE_DUBOIS    = 3'd5;

    // Channel indexes.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Coefficients are scaled by 10000.
    localparam t_coef C_ONE      = 15'sd10000;
    localparam t_coef C_LUMA_R   = 15'sd2990;
    localparam t_coef C_LUMA_G   = 15'sd5870;
    localparam t_coef C_LUMA_B   = 15'sd1140;
    localparam t_coef C_OPT_G    = 15'sd7000;
    localparam t_coef C_OPT_B    = 15'sd3000;

    // Dubois matrix, [output channel][input channel].
    localparam t_coef DUBOIS [3][3] = '{
        '{ 15'sd4045,   15'sd4346,  15'sd1609  },
        '{ 15'sd3298,   15'sd6849,  -15'sd146  },
        '{ -15'sd1162,  -15'sd1902, 15'sd13099 }
    };

    // Rounding and scaling constants.
    localparam int ROUND_HALF = 5000;
    // Rounded sums at or above this value clamp to full scale.
    localparam int SAT_LIMIT  = 2560000;
    localparam int CHAN_MAX   = 255;
    // Division by 10000 as multiplication by ceil(2^36 / 10000), exact for
    // all operands below 2^22.
    localparam int DIV_IN_W   = 22;
    localparam int RECIP_W    = 23;
    localparam int RECIP_SH   = 36;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 23'd6871948;

    // Matrix coefficient for one output channel and one input channel.
    function automatic t_coef mix_coef(input t_mode mode, input logic [1:0] row,
                                       input logic [1:0] col);
        t_coef ident;
        t_coef luma_c;
        t_coef opt_c;
        t_coef c;
        ident = (row == col) ? C_ONE : '0;
        case (col)
            CH_RED:   begin luma_c = C_LUMA_R; opt_c = '0;      end
            CH_GREEN: begin luma_c = C_LUMA_G; opt_c = C_OPT_G; end
            default:  begin luma_c = C_LUMA_B; opt_c = C_OPT_B; end
        endcase
        case (mode)
            MODE_GRAY:      c = luma_c;
            MODE_TRUE:      c = (row == CH_GREEN) ? t_coef'(0) : luma_c;
            MODE_HALF:      c = (row == CH_RED) ? luma_c : ident;
            MODE_OPTIMIZED: c = (row == CH_RED) ? opt_c : ident;
            MODE_DUBOIS:    c = DUBOIS[row][col];
            default:        c = ident;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/atm_mult.sv
// ----------------------------------------------------------------------------
// atm_mult
// First pipeline stage: the nine coefficient by channel products.
// ----------------------------------------------------------------------------
module atm_mult (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  atm_pkg::t_pixel   i_pixel,
    input  atm_pkg::t_mode    i_mode,
    output logic              o_valid,
    input  logic              i_ready,
    output atm_pkg::t_prod_mat o_prod
);
    import atm_pkg::*;

    logic      r_valid;
    t_prod_mat r_prod;
    t_prod_mat n_prod;

    // The stage loads when it is empty or its content moves on.
    assign o_ready = !r_valid || i_ready;

    // Each product is a signed coefficient times a zero-extended channel.
    always_comb begin
        for (int r = 0; r < NUM_CH; r++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                n_prod[r][c] = t_prod'(mix_coef(i_mode, 2'(r), 2'(c)))
                               * t_prod'($signed({1'b0, i_pixel[c]}));
            end
        end
    end

    // Valid bit is control state and is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Product registers.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

FILE: rtl/atm_sum.sv
// ----------------------------------------------------------------------------
// atm_sum
// Second pipeline stage: row sums of the products plus the rounding half.
// ----------------------------------------------------------------------------
module atm_sum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  atm_pkg::t_prod_mat i_prod,
    output logic               o_valid,
    input  logic               i_ready,
    output atm_pkg::t_sum_vec  o_sum
);
    import atm_pkg::*;

    logic     r_valid;
    t_sum_vec r_sum;
    t_sum_vec n_sum;

    assign o_ready = !r_valid || i_ready;

    // Three products and the rounding offset per output channel.
    always_comb begin
        for (int r = 0; r < NUM_CH; r++) begin
            n_sum[r] = t_sum'($signed(i_prod[r][0]) + $signed(i_prod[r][1])
                              + $signed(i_prod[r][2]) + ROUND_HALF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;

endmodule

FILE: rtl/atm_round.sv
// ----------------------------------------------------------------------------
// atm_round
// Third and fourth pipeline stages: division by the coefficient scale through
// a reciprocal product, then clamping into the output register.
// ----------------------------------------------------------------------------
module atm_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  atm_pkg::t_sum_vec i_sum,
    output logic              o_valid,
    input  logic              i_ready,
    output atm_pkg::t_pixel   o_pixel
);
    import atm_pkg::*;

    localparam int MUL_W = DIV_IN_W + RECIP_W;

    // Quotient stage.
    logic                  r_q_valid;
    logic                  q_ready;
    t_pixel                r_quot;
    logic [NUM_CH-1:0]     r_neg;
    logic [NUM_CH-1:0]     r_sat;
    t_pixel                n_quot;
    logic [NUM_CH-1:0]     n_neg;
    logic [NUM_CH-1:0]     n_sat;
    logic [MUL_W-1:0]      mul_full [NUM_CH];

    // Output stage.
    logic                  r_out_valid;
    t_pixel                r_pixel;
    t_pixel                n_pixel;

    assign q_ready = !r_out_valid || i_ready;
    assign o_ready = !r_q_valid || q_ready;

    // Reciprocal multiply; range flags are taken from the full sum.
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            n_neg[k]    = i_sum[k][SUM_W-1];
            n_sat[k]    = !i_sum[k][SUM_W-1] && ($signed(i_sum[k]) >= SAT_LIMIT);
            mul_full[k] = MUL_W'(i_sum[k][DIV_IN_W-1:0]) * MUL_W'(RECIP_MUL);
            n_quot[k]   = mul_full[k][RECIP_SH +: CHAN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (o_ready) begin
            r_q_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_quot <= n_quot;
            r_neg  <= n_neg;
            r_sat  <= n_sat;
        end
    end

    // Clamp: negative sums give zero, large sums give full scale.
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            if (r_neg[k]) begin
                n_pixel[k] = '0;
            end else if (r_sat[k]) begin
                n_pixel[k] = t_chan'(CHAN_MAX);
            end else begin
                n_pixel[k] = r_quot[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (q_ready) begin
            r_out_valid <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_ready && r_q_valid) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_pixel;

endmodule

FILE: rtl/anaglyph_tint_matrix_top.sv
// ----------------------------------------------------------------------------
// anaglyph_tint_matrix_top
// Applies a selectable 3x3 color mix to an RGB pixel stream for red-cyan
// anaglyph viewing, with rounding half away from zero and clamping to 0..255.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the output is not stalled and
// returns one tinted pixel per input transfer, through four register stages:
// products, row sums, reciprocal division by the coefficient scale, and
// clamping into the output register. Throughput is one pixel per cycle
// without back-pressure; each stage holds its item while the next one is
// full, so back-pressure on the output propagates stage by stage without
// dropping data. The tint mode (0 original, 1 gray, 2 true, 3 half,
// 4 optimized, 5 Dubois, 6 and 7 as original) is written through i_cfg_we
// and should only change while no pixel is in flight.
// ----------------------------------------------------------------------------
module anaglyph_tint_matrix_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input pixel stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
    // Output pixel stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
    // Tint mode register write.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata
);
    import atm_pkg::*;

    t_mode     r_mode;
    logic      mult_valid;
    logic      mult_ready;
    t_prod_mat mult_prod;
    logic      sum_valid;
    logic      sum_ready;
    t_sum_vec  sum_val;
    t_pixel    out_pixel;

    // Tint mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ORIGINAL;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // Stage 1: products.
    atm_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_pixel (t_pixel'(i_s_tdata)),
        .i_mode  (r_mode),
        .o_valid (mult_valid),
        .i_ready (mult_ready),
        .o_prod  (mult_prod)
    );

    // Stage 2: row sums.
    atm_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mult_valid),
        .o_ready (mult_ready),
        .i_prod  (mult_prod),
        .o_valid (sum_valid),
        .i_ready (sum_ready),
        .o_sum   (sum_val)
    );

    // Stages 3 and 4: scaling and clamping.
    atm_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid),
        .o_ready (sum_ready),
        .i_sum   (sum_val),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_pixel (out_pixel)
    );

    assign o_m_tdata = 24'(out_pixel);

endmodule
